/* rtl/core/lew_pkg.sv */
// Package for the line editor with word wrap.
// Holds widths, reset values, result codes and the command and status
// structs shared by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lew_pkg;

	localparam int LINE_WIDTH_DEF = 40;
	localparam int BYTE_W         = 8;
	localparam int CNT_W          = 6;
	localparam int ACT_W          = 3;
	localparam int CFG_IDX_W      = 3;

	localparam logic [BYTE_W-1:0] ERASE_RST  = 8'd127;
	localparam logic [BYTE_W-1:0] KILL_RST   = 8'd21;
	localparam logic [BYTE_W-1:0] WERASE_RST = 8'd23;
	localparam logic [BYTE_W-1:0] END_RST    = 8'd4;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

	localparam logic [CFG_IDX_W-1:0] REG_ERASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KILL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WERASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd3;

	typedef enum logic [ACT_W-1:0] {
		ACT_ECHO    = 3'd0,
		ACT_ERASE   = 3'd1,
		ACT_NEWLINE = 3'd2,
		ACT_BELL    = 3'd3,
		ACT_END     = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ECHO_NONE  = 2'd0,
		ECHO_BYTE  = 2'd1,
		ECHO_RDATA = 2'd2
	} echo_src_t;

	typedef enum logic [2:0] {
		CNT_NONE      = 3'd0,
		CNT_ONE       = 3'd1,
		CNT_CURSOR    = 3'd2,
		CNT_CUR_MIN_P = 3'd3,
		CNT_LINE_MIN_P = 3'd4
	} cnt_src_t;

	typedef enum logic [2:0] {
		CUR_HOLD   = 3'd0,
		CUR_INC    = 3'd1,
		CUR_DEC    = 3'd2,
		CUR_ZERO   = 3'd3,
		CUR_FROM_P = 3'd4,
		CUR_LEN    = 3'd5
	} cur_op_t;

	typedef enum logic [2:0] {
		P_HOLD     = 3'd0,
		P_CURSOR   = 3'd1,
		P_LAST_COL = 3'd2,
		P_ZERO     = 3'd3,
		P_DEC      = 3'd4,
		P_INC      = 3'd5
	} p_op_t;

	typedef enum logic [1:0] {
		I_HOLD = 2'd0,
		I_ZERO = 2'd1,
		I_INC  = 2'd2
	} i_op_t;

	typedef enum logic {
		RD_PM1 = 1'b0,
		RD_P   = 1'b1
	} rd_sel_t;

	typedef struct packed {
		logic      load_byte;
		logic      push;
		action_t   act;
		echo_src_t echo_src;
		cnt_src_t  cnt_src;
		logic      last;
		cur_op_t   cur_op;
		p_op_t     p_op;
		i_op_t     i_op;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_byte;
		logic      wr_copy;
		logic      set_finished;
	} lew_cmd_t;

	typedef struct packed {
		logic finished;
		logic is_erase;
		logic is_kill;
		logic is_werase;
		logic is_nl;
		logic is_end;
		logic is_print;
		logic byte_space;
		logic cur_zero;
		logic at_last_col;
		logic p_zero;
		logic p_eq_cursor;
		logic p_at_end;
		logic rd_space;
		logic out_free;
	} lew_status_t;

endpackage

`default_nettype wire

/* rtl/core/lew_ctrl.sv */
// Controller of the line editor: sequences decode, word-erase scan,
// wrap scan and word copy. Depends on lew_pkg for command and status types.
`timescale 1ns / 1ps
`default_nettype none

module lew_ctrl
	import lew_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire lew_status_t st,
	output lew_cmd_t         cmd
);

	typedef enum logic [12:0] {
		S_IDLE      = 13'h0001,
		S_DECODE    = 13'h0002,
		S_WE_NS_RD  = 13'h0004,
		S_WE_NS_CHK = 13'h0008,
		S_WE_SP_RD  = 13'h0010,
		S_WE_SP_CHK = 13'h0020,
		S_WE_OUT    = 13'h0040,
		S_WR_RD     = 13'h0080,
		S_WR_CHK    = 13'h0100,
		S_WR_ERASE  = 13'h0200,
		S_WR_NL     = 13'h0400,
		S_CP_RD     = 13'h0800,
		S_CP_CHK    = 13'h1000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_byte = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (st.finished) begin
					state_d = S_IDLE;
				end else if (st.is_erase) begin
					if (st.out_free) begin
						cmd.push    = 1'b1;
						cmd.act     = ACT_ERASE;
						cmd.cnt_src = CNT_ONE;
						cmd.last    = 1'b1;
						cmd.cur_op  = CUR_DEC;
						state_d     = S_IDLE;
					end
				end else if (st.is_kill) begin
					if (st.cur_zero) begin
						state_d = S_IDLE;
					end else if (st.out_free) begin
						cmd.push    = 1'b1;
						cmd.act     = ACT_ERASE;
						cmd.cnt_src = CNT_CURSOR;
						cmd.last    = 1'b1;
						cmd.cur_op  = CUR_ZERO;
						state_d     = S_IDLE;
					end
				end else if (st.is_werase) begin
					cmd.p_op = P_CURSOR;
					state_d  = S_WE_NS_RD;
				end else if (st.is_nl) begin
					if (st.out_free) begin
						cmd.push   = 1'b1;
						cmd.act    = ACT_NEWLINE;
						cmd.last   = 1'b1;
						cmd.cur_op = CUR_ZERO;
						state_d    = S_IDLE;
					end
				end else if (st.is_end) begin
					if (st.out_free) begin
						cmd.push         = 1'b1;
						cmd.act          = ACT_END;
						cmd.last         = 1'b1;
						cmd.set_finished = 1'b1;
						state_d          = S_IDLE;
					end
				end else if (!st.is_print) begin
					if (st.out_free) begin
						cmd.push = 1'b1;
						cmd.act  = ACT_BELL;
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					if (st.out_free) begin
						cmd.wr_byte  = 1'b1;
						cmd.push     = 1'b1;
						cmd.act      = ACT_ECHO;
						cmd.echo_src = ECHO_BYTE;
						if (st.at_last_col) begin
							if (st.byte_space) begin
								cmd.p_op = P_ZERO;
								state_d  = S_WR_ERASE;
							end else begin
								cmd.p_op = P_LAST_COL;
								state_d  = S_WR_RD;
							end
						end else begin
							cmd.last   = 1'b1;
							cmd.cur_op = CUR_INC;
							state_d    = S_IDLE;
						end
					end
				end
			end
			S_WE_NS_RD: begin
				if (st.p_zero) begin
					state_d = S_WE_OUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PM1;
					state_d    = S_WE_NS_CHK;
				end
			end
			S_WE_NS_CHK: begin
				if (!st.rd_space) begin
					cmd.p_op = P_DEC;
					state_d  = S_WE_NS_RD;
				end else begin
					state_d = S_WE_SP_CHK;
				end
			end
			S_WE_SP_RD: begin
				if (st.p_zero) begin
					state_d = S_WE_OUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PM1;
					state_d    = S_WE_SP_CHK;
				end
			end
			S_WE_SP_CHK: begin
				if (st.rd_space) begin
					cmd.p_op = P_DEC;
					state_d  = S_WE_SP_RD;
				end else begin
					state_d = S_WE_OUT;
				end
			end
			S_WE_OUT: begin
				if (st.p_eq_cursor) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.push    = 1'b1;
					cmd.act     = ACT_ERASE;
					cmd.cnt_src = CNT_CUR_MIN_P;
					cmd.last    = 1'b1;
					cmd.cur_op  = CUR_FROM_P;
					state_d     = S_IDLE;
				end
			end
			S_WR_RD: begin
				if (st.p_zero) begin
					state_d = S_WR_ERASE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PM1;
					state_d    = S_WR_CHK;
				end
			end
			S_WR_CHK: begin
				if (!st.rd_space) begin
					cmd.p_op = P_DEC;
					state_d  = S_WR_RD;
				end else begin
					state_d = S_WR_ERASE;
				end
			end
			S_WR_ERASE: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					if (st.p_zero) begin
						cmd.act    = ACT_NEWLINE;
						cmd.last   = 1'b1;
						cmd.cur_op = CUR_ZERO;
						state_d    = S_IDLE;
					end else begin
						cmd.act     = ACT_ERASE;
						cmd.cnt_src = CNT_LINE_MIN_P;
						cmd.cur_op  = CUR_LEN;
						state_d     = S_WR_NL;
					end
				end
			end
			S_WR_NL: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					cmd.act  = ACT_NEWLINE;
					cmd.i_op = I_ZERO;
					state_d  = S_CP_RD;
				end
			end
			S_CP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_P;
				state_d    = S_CP_CHK;
			end
			S_CP_CHK: begin
				if (st.out_free) begin
					cmd.wr_copy  = 1'b1;
					cmd.push     = 1'b1;
					cmd.act      = ACT_ECHO;
					cmd.echo_src = ECHO_RDATA;
					cmd.last     = st.p_at_end;
					cmd.p_op     = P_INC;
					cmd.i_op     = I_INC;
					state_d      = st.p_at_end ? S_IDLE : S_CP_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/lew_dp.sv */
// Datapath of the line editor: configuration registers, line memory,
// cursor and scan pointers, result register. Depends on lew_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lew_dp
	import lew_pkg::*;
#(
	parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata,
	input  wire logic [BYTE_W-1:0]    typed_byte,
	input  wire lew_cmd_t             cmd,
	output lew_status_t               st,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [ACT_W-1:0]          action,
	output logic [BYTE_W-1:0]         echo_byte,
	output logic [CNT_W-1:0]          erase_count,
	output logic                      last
);

	localparam int AW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
	localparam logic [CNT_W-1:0] LAST_COL = CNT_W'(LINE_WIDTH - 1);
	localparam logic [CNT_W-1:0] LINE_LEN = CNT_W'(LINE_WIDTH);

	logic [BYTE_W-1:0] erase_q, kill_q, werase_q, end_q;
	logic [BYTE_W-1:0] byte_q;
	logic [CNT_W-1:0]  cursor_q, p_q, i_q;
	logic              finished_q;
	logic [BYTE_W-1:0] line_mem [LINE_WIDTH];
	logic [BYTE_W-1:0] rd_q;
	logic [CNT_W-1:0]  p_m1;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              out_valid_q;
	logic [BYTE_W-1:0] echo_d;
	logic [CNT_W-1:0]  cnt_d;

	function automatic logic is_space(input logic [BYTE_W-1:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q  <= ERASE_RST;
			kill_q   <= KILL_RST;
			werase_q <= WERASE_RST;
			end_q    <= END_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_ERASE)  erase_q  <= cfg_wdata;
			if (cfg_index == REG_KILL)   kill_q   <= cfg_wdata;
			if (cfg_index == REG_WERASE) werase_q <= cfg_wdata;
			if (cfg_index == REG_END)    end_q    <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) byte_q <= typed_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q   <= '0;
			finished_q <= 1'b0;
		end else begin
			if (cmd.set_finished) finished_q <= 1'b1;
			unique case (cmd.cur_op)
				CUR_HOLD:   cursor_q <= cursor_q;
				CUR_INC:    cursor_q <= cursor_q + 1'b1;
				CUR_DEC:    cursor_q <= cursor_q - 1'b1;
				CUR_ZERO:   cursor_q <= '0;
				CUR_FROM_P: cursor_q <= p_q;
				CUR_LEN:    cursor_q <= LINE_LEN - p_q;
				default:    cursor_q <= cursor_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.p_op)
			P_HOLD:     p_q <= p_q;
			P_CURSOR:   p_q <= cursor_q;
			P_LAST_COL: p_q <= LAST_COL;
			P_ZERO:     p_q <= '0;
			P_DEC:      p_q <= p_m1;
			P_INC:      p_q <= p_q + 1'b1;
			default:    p_q <= p_q;
		endcase
		unique case (cmd.i_op)
			I_HOLD:  i_q <= i_q;
			I_ZERO:  i_q <= '0;
			I_INC:   i_q <= i_q + 1'b1;
			default: i_q <= i_q;
		endcase
	end

	assign p_m1    = p_q - 1'b1;
	assign rd_addr = (cmd.rd_sel == RD_PM1) ? p_m1[AW-1:0] : p_q[AW-1:0];
	assign wr_addr = cmd.wr_byte ? cursor_q[AW-1:0] : i_q[AW-1:0];
	assign wr_data = cmd.wr_byte ? byte_q : rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_byte || cmd.wr_copy) line_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rd_q <= line_mem[rd_addr];
	end

	always_comb begin
		unique case (cmd.echo_src)
			ECHO_NONE:  echo_d = '0;
			ECHO_BYTE:  echo_d = byte_q;
			ECHO_RDATA: echo_d = rd_q;
			default:    echo_d = '0;
		endcase
		unique case (cmd.cnt_src)
			CNT_NONE:       cnt_d = '0;
			CNT_ONE:        cnt_d = CNT_W'(1);
			CNT_CURSOR:     cnt_d = cursor_q;
			CNT_CUR_MIN_P:  cnt_d = cursor_q - p_q;
			CNT_LINE_MIN_P: cnt_d = LINE_LEN - p_q;
			default:        cnt_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			action      <= cmd.act;
			echo_byte   <= echo_d;
			erase_count <= cnt_d;
			last        <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		st.finished    = finished_q;
		st.is_erase    = (cursor_q != '0) && (byte_q == erase_q);
		st.is_kill     = (byte_q == kill_q);
		st.is_werase   = (byte_q == werase_q);
		st.is_nl       = (byte_q == CH_NEWLINE);
		st.is_end      = (cursor_q == '0) && (byte_q == end_q);
		st.is_print    = (byte_q >= 8'h20) && (byte_q <= 8'h7E);
		st.byte_space  = is_space(byte_q);
		st.cur_zero    = (cursor_q == '0);
		st.at_last_col = (cursor_q == LAST_COL);
		st.p_zero      = (p_q == '0);
		st.p_eq_cursor = (p_q == cursor_q);
		st.p_at_end    = (p_q == LAST_COL);
		st.rd_space    = is_space(rd_q);
		st.out_free    = !out_valid_q || !out_stall;
	end

`ifndef ASSERT_OFF
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q < LINE_LEN)
		else $error("cursor out of line");
	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_copy |-> (i_q < p_q))
		else $error("copy destination not below source");
	a_scan_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && (cmd.rd_sel == RD_PM1)) |-> (p_q != '0))
		else $error("scan read below column zero");
`endif

endmodule

`default_nettype wire

/* rtl/core/line_editor_word_wrap.sv */
// Line editor with word wrap: one typed byte in, zero or more echo words out.
// Built from lew_ctrl and lew_dp; depends on lew_pkg.
//
// A plain byte is registered on acceptance and then decoded into its result
// word, which waits out any output stall. Word erase scans the line memory
// backward, reading and then testing each character examined, since each
// memory read is registered before it is tested. A wrap scans the characters
// of the last word, emits the erase word (if a word is moved) and the newline
// word and re-echoes the moved characters; a byte arriving while a wrap is in
// progress is held off by in_stall. The line memory needs no clearing after
// reset. Write configuration only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module line_editor_word_wrap
	import lew_pkg::*;
#(
	parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [BYTE_W-1:0]    typed_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [ACT_W-1:0]          action,
	output logic [BYTE_W-1:0]         echo_byte,
	output logic [CNT_W-1:0]          erase_count,
	output logic                      last
);

	lew_cmd_t    cmd;
	lew_status_t st;

	lew_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	lew_dp #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.typed_byte  (typed_byte),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.action      (action),
		.echo_byte   (echo_byte),
		.erase_count (erase_count),
		.last        (last)
	);

endmodule

`default_nettype wire

/* dv/line_editor_word_wrap_tb.sv */
// Self-checking testbench for line_editor_word_wrap: typed bytes in, echo words out.
// Runs a directed table, then random typing under three register settings and idle profiles.
// Depends on lew_pkg and the line_editor_word_wrap RTL only.
`timescale 1ns / 1ps

module line_editor_word_wrap_tb;
	import lew_pkg::*;

	localparam int LINE_W = LINE_WIDTH_DEF;
	localparam int DIR_ROWS = 25;
	localparam int PHASE_ITEMS = 115;
	localparam int SETTLE_CYCLES = 4 * LINE_W + 40;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		ROW_PREDICT = 2'd0,
		ROW_NONE    = 2'd1,
		ROW_ONE     = 2'd2
	} row_kind_t;

	typedef struct packed {
		action_t           act;
		logic [BYTE_W-1:0] ch;
		logic [CNT_W-1:0]  cnt;
		logic              fin;
	} echo_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		row_kind_t         kind;
		echo_word_t        want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [BYTE_W-1:0]    typed_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [ACT_W-1:0]     action;
	logic [BYTE_W-1:0]    echo_byte;
	logic [CNT_W-1:0]     erase_count;
	logic                 last;

	logic [BYTE_W-1:0] erase_ch, kill_ch, werase_ch, end_ch;
	logic [BYTE_W-1:0] line_buf [LINE_W];
	int                col;
	logic              ended;

	echo_word_t        line_words [$];
	echo_word_t        echo_words_due [$];
	logic [BYTE_W-1:0] plan [$];
	stim_row_t         dir_rows [DIR_ROWS];

	int   word_left;
	int   send_idle;
	int   recv_idle;
	logic hold_req;
	int   quiet_cycles;
	int   n_errors;
	int   n_checked;
	int   n_typed;
	int   n_wraps;

	line_editor_word_wrap u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.typed_byte  (typed_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.action      (action),
		.echo_byte   (echo_byte),
		.erase_count (erase_count),
		.last        (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_glyph(input logic [BYTE_W-1:0] c);
		return c >= 8'h20 && c <= 8'h7E;
	endfunction

	function automatic logic ends_input(input logic [BYTE_W-1:0] b);
		return col == 0 && b == end_ch && b != kill_ch && b != werase_ch && b != CH_NEWLINE;
	endfunction

	function automatic void add_word(input action_t a, input logic [BYTE_W-1:0] ch,
			input int n);
		echo_word_t w;
		w.act = a;
		w.ch = ch;
		w.cnt = CNT_W'(n);
		w.fin = 1'b0;
		line_words.push_back(w);
	endfunction

	function automatic void edit_line(input logic [BYTE_W-1:0] b);
		int p;
		int len;
		int i;
		echo_word_t w;
		line_words.delete();
		if (ended)
			return;
		if (col > 0 && b == erase_ch) begin
			add_word(ACT_ERASE, '0, 1);
			col--;
		end else if (b == kill_ch) begin
			if (col > 0)
				add_word(ACT_ERASE, '0, col);
			col = 0;
		end else if (b == werase_ch) begin
			p = col;
			while (p > 0 && !is_blank(line_buf[p-1]))
				p--;
			while (p > 0 && is_blank(line_buf[p-1]))
				p--;
			if (p < col)
				add_word(ACT_ERASE, '0, col - p);
			col = p;
		end else if (b == CH_NEWLINE) begin
			add_word(ACT_NEWLINE, '0, 0);
			col = 0;
		end else if (col == 0 && b == end_ch) begin
			add_word(ACT_END, '0, 0);
			ended = 1'b1;
		end else if (!is_glyph(b)) begin
			add_word(ACT_BELL, '0, 0);
		end else begin
			line_buf[col] = b;
			add_word(ACT_ECHO, b, 0);
			col++;
			if (col >= LINE_W) begin
				p = LINE_W;
				if (!is_blank(line_buf[LINE_W-1]))
					while (p > 0 && !is_blank(line_buf[p-1]))
						p--;
				if (p > 0 && p < LINE_W) begin
					len = LINE_W - p;
					add_word(ACT_ERASE, '0, len);
					add_word(ACT_NEWLINE, '0, 0);
					for (i = 0; i < len; i++) begin
						line_buf[i] = line_buf[p + i];
						add_word(ACT_ECHO, line_buf[i], 0);
					end
					col = len;
					n_wraps++;
				end else begin
					add_word(ACT_NEWLINE, '0, 0);
					col = 0;
				end
			end
		end
		if (line_words.size() > 0) begin
			w = line_words.pop_back();
			w.fin = 1'b1;
			line_words.push_back(w);
		end
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		logic [BYTE_W-1:0] b;
		r = $urandom_range(0, 99);
		if (plan.size() > 0) begin
			b = plan.pop_front();
		end else if (col == LINE_W - 1 && r < 30) begin
			b = CH_SPACE;
		end else if (r < 82) begin
			if (word_left == 0) begin
				b = CH_SPACE;
				word_left = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 45)
					: $urandom_range(1, 8);
			end else begin
				b = BYTE_W'($urandom_range(8'h21, 8'h7E));
				word_left--;
			end
		end else if (r < 87) begin
			b = erase_ch;
		end else if (r < 88) begin
			b = kill_ch;
		end else if (r < 91) begin
			b = werase_ch;
		end else if (r < 92) begin
			b = CH_NEWLINE;
		end else begin
			b = BYTE_W'($urandom_range(0, 255));
		end
		while (ends_input(b))
			b = BYTE_W'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic plan_letters(input int n);
		repeat (n)
			plan.push_back(BYTE_W'($urandom_range(8'h61, 8'h7A)));
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [BYTE_W-1:0] b, input row_kind_t kind,
			input echo_word_t want);
		int i;
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		typed_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		edit_line(b);
		n_typed++;
		if (kind == ROW_ONE)
			echo_words_due.push_back(want);
		else if (kind == ROW_PREDICT)
			for (i = 0; i < line_words.size(); i++)
				echo_words_due.push_back(line_words[i]);
		@(negedge clk);
	endtask

	task automatic run_phase(input int n);
		repeat (n)
			send_byte(pick_byte(), ROW_PREDICT, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (echo_words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_ERASE:  erase_ch = val;
			REG_KILL:   kill_ch = val;
			REG_WERASE: werase_ch = val;
			REG_END:    end_ch = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_regs(input logic [BYTE_W-1:0] e, k, w, n);
		write_reg(REG_ERASE, e);
		write_reg(REG_KILL, k);
		write_reg(REG_WERASE, w);
		write_reg(REG_END, n);
		write_reg(REG_SPARE, BYTE_W'($urandom_range(0, 255)));
		cfg_we <= 1'b0;
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_req = 1'b0;
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	always @(posedge clk) begin : check_words
		echo_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (echo_words_due.size() == 0) begin
				$error("unexpected word: action %0d echo_byte %0h erase_count %0d last %0b",
					action, echo_byte, erase_count, last);
				n_errors++;
			end else begin
				want = echo_words_due.pop_front();
				n_checked++;
				if (action !== want.act) begin
					$error("action: expected %0d, got %0d", want.act, action);
					n_errors++;
				end
				if (echo_byte !== want.ch) begin
					$error("echo_byte: expected %0h, got %0h", want.ch, echo_byte);
					n_errors++;
				end
				if (erase_count !== want.cnt) begin
					$error("erase_count: expected %0d, got %0d", want.cnt, erase_count);
					n_errors++;
				end
				if (last !== want.fin) begin
					$error("last: expected %0b, got %0b", want.fin, last);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no handshake for %0d cycles, %0d words outstanding",
				quiet_cycles, echo_words_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ERASE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		typed_byte = '0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		n_errors = 0;
		n_checked = 0;
		n_typed = 0;
		n_wraps = 0;
		word_left = 0;
		erase_ch = ERASE_RST;
		kill_ch = KILL_RST;
		werase_ch = WERASE_RST;
		end_ch = END_RST;
		col = 0;
		ended = 1'b0;
		for (k = 0; k < LINE_W; k++)
			line_buf[k] = '0;
		dir_rows = '{
			'{8'h7F, ROW_ONE,     '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
			'{8'h15, ROW_NONE,    '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h17, ROW_NONE,    '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h00, ROW_ONE,     '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
			'{8'h20, ROW_ONE,     '{ACT_ECHO,    8'h20, 6'd0, 1'b1}},
			'{8'h7E, ROW_ONE,     '{ACT_ECHO,    8'h7E, 6'd0, 1'b1}},
			'{8'h41, ROW_ONE,     '{ACT_ECHO,    8'h41, 6'd0, 1'b1}},
			'{8'h04, ROW_ONE,     '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
			'{8'h80, ROW_ONE,     '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
			'{8'hFF, ROW_ONE,     '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
			'{8'h09, ROW_ONE,     '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
			'{8'h7F, ROW_ONE,     '{ACT_ERASE,   8'h00, 6'd1, 1'b1}},
			'{8'h17, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h78, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h79, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h20, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h7A, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h17, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h15, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h0A, ROW_ONE,     '{ACT_NEWLINE, 8'h00, 6'd0, 1'b1}},
			'{8'h55, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h0A, ROW_ONE,     '{ACT_NEWLINE, 8'h00, 6'd0, 1'b1}},
			'{8'h0D, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h2A, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}},
			'{8'h15, ROW_PREDICT, '{ACT_ECHO,    8'h00, 6'd0, 1'b0}}
		};
		send_idle = 12;
		recv_idle = 67;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DIR_ROWS; k++)
			send_byte(dir_rows[k].b, dir_rows[k].kind, dir_rows[k].want);

		// single word filling the whole line
		plan.push_back(kill_ch);
		plan_letters(42);
		run_phase(PHASE_ITEMS);
		drain();

		send_idle = 67;
		recv_idle = 12;
		write_regs(8'h00, 8'hFF, 8'h08, 8'h1B);
		// full line whose last column is a space
		plan.push_back(kill_ch);
		repeat (4) begin
			plan_letters(9);
			plan.push_back(CH_SPACE);
		end
		plan_letters(2);
		run_phase(PHASE_ITEMS);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_regs(8'h23, 8'h40, 8'h0A, 8'hFF);
		hold_req = 1'b1;
		// longest wrap: one leading space, then a word to the end of the line
		plan.push_back(kill_ch);
		plan.push_back(CH_SPACE);
		plan_letters(41);
		run_phase(PHASE_ITEMS);

		send_byte(kill_ch, ROW_PREDICT, '0);
		send_byte(end_ch, ROW_PREDICT, '0);
		repeat (4)
			send_byte(BYTE_W'($urandom_range(0, 255)), ROW_PREDICT, '0);
		drain();

		$display("typed %0d bytes, checked %0d echo words, %0d word wraps", n_typed,
			n_checked, n_wraps);
		$display("three register settings, three idle profiles, end of input at the close");
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
